// File: hw/rtl/scm_pkg.sv
// ----------------------------------------------------------------------------
// scm_pkg
// Shared sizes, command and status structs and controller states for the
// sigma-clipped mean unit.
// ----------------------------------------------------------------------------
package scm_pkg;

    localparam int SAMPLE_COUNT = 16;
    localparam int SAMPLE_BITS  = 16;

    localparam int IN_BITS      = 16;
    localparam int RAW_BITS     = 24;
    localparam int MEAN_BITS    = 24;
    localparam int COUNT_BITS   = 5;
    localparam int FRAC_BITS    = 8;
    localparam int COUNT_MAX    = 31;
    localparam int MEAN_MIN_MAG = 8388608;
    localparam int MEAN_MAX     = 8388607;

    localparam int IDX_BITS   = $clog2(SAMPLE_COUNT);
    localparam int CNT_BITS   = $clog2(SAMPLE_COUNT + 1);
    localparam int SUM_BITS   = SAMPLE_BITS + IDX_BITS + 1;
    localparam int SQ_BITS    = 2 * SAMPLE_BITS;
    localparam int SQSUM_BITS = 2 * SAMPLE_BITS + IDX_BITS;
    localparam int WIDE_BITS  = 2 * SUM_BITS;
    localparam int NUM_BITS   = SUM_BITS + FRAC_BITS;
    localparam int STEP_BITS  = $clog2(NUM_BITS);
    localparam int OUT_BITS   = ((MEAN_BITS + COUNT_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic load;
        logic square;
        logic accum;
        logic spread_mul;
        logic spread_sub;
        logic rd;
        logic dev;
        logic dev_sq;
        logic cmp;
        logic div_init;
        logic div_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic batch_full;
        logic last_entry;
        logic div_done;
        logic out_free;
    } t_stat;

    typedef enum logic [11:0] {
        ST_IDLE       = 12'b0000_0000_0001,
        ST_SQUARE     = 12'b0000_0000_0010,
        ST_ACCUM      = 12'b0000_0000_0100,
        ST_SPREAD_MUL = 12'b0000_0000_1000,
        ST_SPREAD_SUB = 12'b0000_0001_0000,
        ST_READ       = 12'b0000_0010_0000,
        ST_DEV        = 12'b0000_0100_0000,
        ST_DEV_SQ     = 12'b0000_1000_0000,
        ST_CMP        = 12'b0001_0000_0000,
        ST_DIV_INIT   = 12'b0010_0000_0000,
        ST_DIV        = 12'b0100_0000_0000,
        ST_FINISH     = 12'b1000_0000_0000
    } t_state;

endpackage

// File: hw/rtl/scm_ctrl.sv
// ----------------------------------------------------------------------------
// scm_ctrl
// Controller state machine: sequences loading, the clipping pass, the
// division and the hand-off to the output register.
// ----------------------------------------------------------------------------
module scm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  scm_pkg::t_stat i_stat,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    output scm_pkg::t_cmd  o_cmd,
    output scm_pkg::t_state o_state
);
    import scm_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.load = i_s_tvalid;
                if (i_s_tvalid) begin
                    n_state = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                o_cmd.square = 1'b1;
                n_state      = ST_ACCUM;
            end
            ST_ACCUM: begin
                o_cmd.accum = 1'b1;
                n_state     = i_stat.batch_full ? ST_SPREAD_MUL : ST_IDLE;
            end
            ST_SPREAD_MUL: begin
                o_cmd.spread_mul = 1'b1;
                n_state          = ST_SPREAD_SUB;
            end
            ST_SPREAD_SUB: begin
                o_cmd.spread_sub = 1'b1;
                n_state          = ST_READ;
            end
            ST_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_DEV;
            end
            ST_DEV: begin
                o_cmd.dev = 1'b1;
                n_state   = ST_DEV_SQ;
            end
            ST_DEV_SQ: begin
                o_cmd.dev_sq = 1'b1;
                n_state      = ST_CMP;
            end
            ST_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = i_stat.last_entry ? ST_DIV_INIT : ST_READ;
            end
            ST_DIV_INIT: begin
                o_cmd.div_init = 1'b1;
                n_state        = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_done) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                o_cmd.finish = i_stat.out_free;
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_state    = r_state;

endmodule

// File: hw/rtl/scm_datapath.sv
// ----------------------------------------------------------------------------
// scm_datapath
// Sample store, running sums, deviation test, serial divider and the
// output register of the sigma-clipped mean unit.
// ----------------------------------------------------------------------------
module scm_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  scm_pkg::t_cmd                    i_cmd,
    output scm_pkg::t_stat                   o_stat,
    input  logic [scm_pkg::IN_BITS-1:0]      i_sample,
    input  logic                             i_m_tready,
    output logic                             o_m_tvalid,
    output logic [scm_pkg::MEAN_BITS-1:0]    o_mean,
    output logic [scm_pkg::COUNT_BITS-1:0]   o_count
);
    import scm_pkg::*;

    localparam logic signed [SUM_BITS:0] N_CONST = (SUM_BITS + 1)'(SAMPLE_COUNT);

    logic [SAMPLE_BITS-1:0] r_mem [SAMPLE_COUNT];

    logic        [RAW_BITS-1:0]    w_raw;
    logic signed [SAMPLE_BITS-1:0] w_x;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic signed [SQ_BITS-1:0]     r_sq;
    logic signed [SUM_BITS-1:0]    r_sum;
    logic        [SQSUM_BITS-1:0]  r_sqsum;
    logic        [CNT_BITS-1:0]    r_fill;
    logic signed [WIDE_BITS-1:0]   r_s2;
    logic        [WIDE_BITS-1:0]   r_nq;
    logic signed [WIDE_BITS-1:0]   w_diff;
    logic        [WIDE_BITS-1:0]   r_spread;
    logic        [IDX_BITS-1:0]    r_idx;
    logic signed [SAMPLE_BITS-1:0] r_rdata;
    logic signed [SAMPLE_BITS-1:0] r_cx;
    logic signed [SUM_BITS:0]      w_dev;
    logic        [SUM_BITS-1:0]    r_mag;
    logic        [WIDE_BITS-1:0]   r_dsq;
    logic signed [SUM_BITS-1:0]    r_ksum;
    logic        [CNT_BITS-1:0]    r_kept;
    logic                          r_neg;
    logic        [SUM_BITS-1:0]    w_kmag;
    logic        [NUM_BITS-1:0]    r_quo;
    logic        [CNT_BITS-1:0]    r_rem;
    logic        [STEP_BITS-1:0]   r_step;
    logic        [CNT_BITS:0]      w_shift;
    logic        [CNT_BITS:0]      w_trial;
    logic                          w_ge;
    logic signed [NUM_BITS:0]      w_qsigned;
    logic        [MEAN_BITS-1:0]   w_mean;
    logic        [COUNT_BITS-1:0]  w_count;
    logic                          r_out_valid;
    logic        [MEAN_BITS-1:0]   r_out_mean;
    logic        [COUNT_BITS-1:0]  r_out_count;

    assign w_raw  = {{(RAW_BITS - IN_BITS){1'b0}}, i_sample};
    assign w_x    = w_raw[SAMPLE_BITS-1:0];
    assign w_diff = $signed(r_nq) - r_s2;
    assign w_dev  = (SUM_BITS + 1)'(r_rdata) * N_CONST - (SUM_BITS + 1)'(r_sum);
    assign w_kmag = r_ksum[SUM_BITS-1] ? SUM_BITS'(-r_ksum) : r_ksum;

    // Restoring division step: the remainder stays below the divisor when the divisor is nonzero.
    assign w_shift = {r_rem, r_quo[NUM_BITS-1]};
    assign w_ge    = (w_shift >= {1'b0, r_kept});
    assign w_trial = w_shift - {1'b0, r_kept};

    assign w_qsigned = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});

    always_comb begin
        if (r_kept == '0) begin
            w_mean = '0;
        end else if (r_neg && (64'(r_quo) > 64'(MEAN_MIN_MAG))) begin
            w_mean = {1'b1, {(MEAN_BITS - 1){1'b0}}};
        end else if (!r_neg && (64'(r_quo) > 64'(MEAN_MAX))) begin
            w_mean = {1'b0, {(MEAN_BITS - 1){1'b1}}};
        end else begin
            w_mean = MEAN_BITS'(w_qsigned);
        end
        if (32'(r_kept) > 32'(COUNT_MAX)) begin
            w_count = COUNT_BITS'(COUNT_MAX);
        end else begin
            w_count = COUNT_BITS'(r_kept);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mem[r_fill[IDX_BITS-1:0]] <= w_x;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x <= w_x;
        end
        if (i_cmd.square) begin
            r_sq <= r_x * r_x;
        end
        if (i_cmd.spread_mul) begin
            r_s2 <= r_sum * r_sum;
            r_nq <= WIDE_BITS'(r_sqsum) * WIDE_BITS'(SAMPLE_COUNT);
        end
        if (i_cmd.spread_sub) begin
            r_spread <= w_diff[WIDE_BITS-1] ? '0 : w_diff;
        end
        if (i_cmd.dev) begin
            r_cx  <= r_rdata;
            r_mag <= w_dev[SUM_BITS] ? SUM_BITS'(-w_dev) : w_dev[SUM_BITS-1:0];
        end
        if (i_cmd.dev_sq) begin
            r_dsq <= WIDE_BITS'(r_mag) * WIDE_BITS'(r_mag);
        end
        if (i_cmd.div_init) begin
            r_neg <= r_ksum[SUM_BITS-1];
            r_quo <= {w_kmag, {FRAC_BITS{1'b0}}};
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[NUM_BITS-2:0], w_ge};
            r_rem <= w_ge ? w_trial[CNT_BITS-1:0] : w_shift[CNT_BITS-1:0];
        end
        if (i_cmd.finish) begin
            r_out_mean  <= w_mean;
            r_out_count <= w_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_sqsum     <= '0;
            r_fill      <= '0;
            r_idx       <= '0;
            r_ksum      <= '0;
            r_kept      <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accum) begin
                r_sum   <= r_sum + SUM_BITS'(r_x);
                r_sqsum <= r_sqsum + SQSUM_BITS'($unsigned(r_sq));
                r_fill  <= r_fill + 1'b1;
            end
            if (i_cmd.spread_sub) begin
                r_idx  <= '0;
                r_ksum <= '0;
                r_kept <= '0;
            end
            if (i_cmd.cmp) begin
                r_idx <= r_idx + 1'b1;
                if (r_dsq <= r_spread) begin
                    r_ksum <= r_ksum + SUM_BITS'(r_cx);
                    r_kept <= r_kept + 1'b1;
                end
            end
            if (i_cmd.div_init) begin
                r_step <= '0;
            end else if (i_cmd.div_step) begin
                r_step <= r_step + 1'b1;
            end
            if (i_cmd.finish) begin
                r_sum       <= '0;
                r_sqsum     <= '0;
                r_fill      <= '0;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.batch_full = (r_fill == CNT_BITS'(SAMPLE_COUNT - 1));
    assign o_stat.last_entry = (r_idx == IDX_BITS'(SAMPLE_COUNT - 1));
    assign o_stat.div_done   = (r_step == STEP_BITS'(NUM_BITS - 1));
    assign o_stat.out_free   = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_mean     = r_out_mean;
    assign o_count    = r_out_count;

endmodule

// File: hw/rtl/sigma_clipped_mean_unit.sv
// ----------------------------------------------------------------------------
// sigma_clipped_mean_unit
// Mean of a batch of signed samples after dropping those farther than one
// standard deviation from the batch mean.
//
// Samples enter on the s_axis channel, one item per sample. Every group of
// SAMPLE_COUNT items forms a batch, and one result item leaves on the m_axis
// channel per batch: the kept mean with 8 fraction bits and the kept count.
// Each sample is loaded, squared and accumulated in turn; the sample store is
// written once and read back in a second pass, where each entry is read, its
// deviation formed and squared, and then compared. After the last sample of a
// batch the result reaches the output register through the spread steps, the
// pass over the store and the one-bit-per-cycle divider.
// The result waits in an output register, so loading of the next batch goes
// on while the receiver stalls; a finished batch holds there until the
// previous result has been taken. Reset empties the batch and drops any
// pending result.
// ----------------------------------------------------------------------------
module sigma_clipped_mean_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [scm_pkg::IN_BITS-1:0]     s_axis_tdata,  // [15:0] sample
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [scm_pkg::OUT_BITS-1:0]    m_axis_tdata   // [23:0] clipped_mean,
                                                           // [28:24] kept_count
);
    import scm_pkg::*;

    t_cmd                  w_cmd;
    t_stat                 w_stat;
    t_state                w_state;
    logic [MEAN_BITS-1:0]  w_mean;
    logic [COUNT_BITS-1:0] w_count;

    scm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_stat     (w_stat),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_cmd      (w_cmd),
        .o_state    (w_state)
    );

    scm_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_sample   (s_axis_tdata),
        .i_m_tready (m_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .o_mean     (w_mean),
        .o_count    (w_count)
    );

    assign m_axis_tdata = {(OUT_BITS - MEAN_BITS - COUNT_BITS)'(0), w_count, w_mean};

    a_accept_to_square: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (w_state == ST_SQUARE))
        else $error("Accepted item did not start the square step.");

    a_result_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_state == ST_FINISH))
        else $error("Result appeared outside the finish step.");

    a_kept_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_count != '0))
        else $error("Result reports no kept samples.");

endmodule

// File: tb/sv/sigma_clipped_mean_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sigma_clipped_mean_unit_test
// Self-checking bench for the sigma-clipped mean unit. Batches of samples are
// streamed in with random gaps while the result side stalls at random and
// once for a long stretch. A behavioral predictor works out the kept mean and
// count of every batch, and each result item is compared field by field.
// ----------------------------------------------------------------------------
module sigma_clipped_mean_unit_test;
    import scm_pkg::*;

    localparam int HOLD_CYCLES    = 1200;
    localparam int DRAIN_CYCLES   = 120;
    localparam int RANDOM_BATCHES = 101;
    localparam int SENDER         = 0;
    localparam int RECEIVER       = 1;

    typedef struct packed {
        logic [MEAN_BITS-1:0]  mean;
        logic [COUNT_BITS-1:0] count;
    } batch_result_t;

    typedef struct packed {
        logic [IN_BITS-1:0] base;
        logic [IN_BITS-1:0] odd;
        logic [4:0]         odd_count;
        logic               pinned;
        batch_result_t      result;
    } batch_plan_t;

    typedef enum logic [1:0] {
        SHAPE_UNIFORM,
        SHAPE_CLUSTER,
        SHAPE_FLAT,
        SHAPE_TWO_LEVEL
    } batch_shape_t;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [IN_BITS-1:0]  s_axis_tdata  = '0;  // [15:0] sample
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OUT_BITS-1:0] m_axis_tdata;        // [23:0] clipped_mean, [28:24] kept_count

    logic signed [SAMPLE_BITS-1:0] batch_store [SAMPLE_COUNT];
    longint        batch_sum        = 0;
    longint        batch_square_sum = 0;
    int            batch_fill       = 0;
    batch_result_t pending_results [$];
    logic          pin_active = 1'b0;
    batch_result_t pin_result = '0;
    int            failures     = 0;
    int            samples_sent = 0;
    int            batches_sent = 0;
    int            results_seen = 0;
    bit            no_idle [2]      = '{1'b0, 1'b0};
    int            stretch_left [2] = '{0, 0};

    sigma_clipped_mean_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    function automatic int draw_gap(input int side);
        if (stretch_left[side] == 0) begin
            stretch_left[side] = $urandom_range(150, 20);
            no_idle[side] = ($urandom_range(2) == 0);
        end
        stretch_left[side]--;
        return no_idle[side] ? 0 : int'($urandom_range(12));
    endfunction

    function automatic bit absorb_sample(input logic [IN_BITS-1:0] raw,
                                         output batch_result_t res);
        logic signed [SAMPLE_BITS-1:0] x;
        longint spread;
        longint dev;
        longint kept_sum;
        longint mean;
        longint unsigned mag;
        int kept;
        x = raw[SAMPLE_BITS-1:0];
        res = '0;
        if (batch_fill >= SAMPLE_COUNT) begin
            batch_fill = 0;
        end
        batch_store[batch_fill] = x;
        batch_sum += longint'(x);
        batch_square_sum += longint'(x) * longint'(x);
        batch_fill++;
        if (batch_fill < SAMPLE_COUNT) begin
            return 1'b0;
        end
        spread = longint'(SAMPLE_COUNT) * batch_square_sum - batch_sum * batch_sum;
        if (spread < 0) begin
            spread = 0;
        end
        kept_sum = 0;
        kept = 0;
        for (int i = 0; i < SAMPLE_COUNT; i++) begin
            dev = longint'(SAMPLE_COUNT) * longint'(batch_store[i]) - batch_sum;
            mag = (dev < 0) ? longint'(-dev) : dev;
            if (mag <= 64'hFFFF_FFFF && mag * mag <= longint'(spread)) begin
                kept_sum += longint'(batch_store[i]);
                kept++;
            end
        end
        mean = 0;
        if (kept != 0) begin
            mean = (kept_sum * 256) / longint'(kept);
            if (mean > MEAN_MAX) begin
                mean = MEAN_MAX;
            end
            if (mean < -longint'(MEAN_MIN_MAG)) begin
                mean = -longint'(MEAN_MIN_MAG);
            end
        end
        if (kept > COUNT_MAX) begin
            kept = COUNT_MAX;
        end
        res.mean = mean[MEAN_BITS-1:0];
        res.count = kept[COUNT_BITS-1:0];
        batch_sum = 0;
        batch_square_sum = 0;
        batch_fill = 0;
        return 1'b1;
    endfunction

    task automatic send_sample(input logic [IN_BITS-1:0] value);
        int gap;
        batch_result_t res;
        gap = draw_gap(SENDER);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= value;
        do @(posedge i_clk); while (!s_axis_tready);
        samples_sent++;
        if (absorb_sample(value, res)) begin
            pending_results.push_back(pin_active ? pin_result : res);
            batches_sent++;
        end
    endtask

    initial begin : result_sink
        int gap;
        bit held;
        batch_result_t got;
        batch_result_t want;
        held = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            // After a few results, stall the output long enough to back up the input.
            if (results_seen == 3 && !held) begin
                gap = HOLD_CYCLES;
                held = 1'b1;
            end else begin
                gap = draw_gap(RECEIVER);
            end
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            got.mean = m_axis_tdata[MEAN_BITS-1:0];
            got.count = m_axis_tdata[MEAN_BITS+COUNT_BITS-1:MEAN_BITS];
            results_seen++;
            if (pending_results.size() == 0) begin
                failures++;
                if (failures <= 10) begin
                    $display("Unexpected result: mean %0d count %0d",
                             $signed(got.mean), got.count);
                end
            end else begin
                want = pending_results.pop_front();
                if (got.mean !== want.mean || got.count !== want.count) begin
                    failures++;
                    if (failures <= 10) begin
                        $display("Result %0d mismatch: mean %0d (expected %0d), count %0d (expected %0d)",
                                 results_seen, $signed(got.mean), $signed(want.mean),
                                 got.count, want.count);
                    end
                end
            end
        end
    end

    initial begin : stimulus
        batch_plan_t directed_plan [5];
        batch_shape_t shape;
        int center;
        int width;
        int level_b;
        int v;
        directed_plan[0] = '{16'h7FFF, 16'h7FFF, 5'd0, 1'b1, '{24'h7FFF00, 5'd16}};
        directed_plan[1] = '{16'h8000, 16'h8000, 5'd0, 1'b1, '{24'h800000, 5'd16}};
        directed_plan[2] = '{16'h0064, 16'h7530, 5'd1, 1'b1, '{24'h006400, 5'd15}};
        directed_plan[3] = '{16'h7FFF, 16'h8000, 5'd8, 1'b0, '0};
        directed_plan[4] = '{16'h5555, 16'hAAAA, 5'd5, 1'b0, '0};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_plan[r]) begin
            pin_active = directed_plan[r].pinned;
            pin_result = directed_plan[r].result;
            for (int k = 0; k < SAMPLE_COUNT; k++) begin
                send_sample((k < directed_plan[r].odd_count) ? directed_plan[r].odd
                                                             : directed_plan[r].base);
            end
        end
        pin_active = 1'b0;

        for (int b = 0; b < RANDOM_BATCHES; b++) begin
            shape = batch_shape_t'($urandom_range(3));
            center = int'($urandom_range(65535)) - 32768;
            width = 1 << $urandom_range(15);
            level_b = int'($urandom_range(65535)) - 32768;
            for (int k = 0; k < SAMPLE_COUNT; k++) begin
                case (shape)
                    SHAPE_UNIFORM: begin
                        v = int'($urandom_range(65535)) - 32768;
                    end
                    SHAPE_CLUSTER: begin
                        if ($urandom_range(7) == 0) begin
                            v = int'($urandom_range(65535)) - 32768;
                        end else begin
                            v = center + int'($urandom_range(2 * width)) - width;
                        end
                    end
                    SHAPE_FLAT: begin
                        v = center;
                    end
                    default: begin
                        v = ($urandom_range(1) == 0) ? center : level_b;
                    end
                endcase
                if (v > 32767) begin
                    v = 32767;
                end
                if (v < -32768) begin
                    v = -32768;
                end
                send_sample(v[IN_BITS-1:0]);
            end
        end
        s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Streamed %0d samples in %0d batches (directed extremes, outliers, flat,",
                 samples_sent, batches_sent);
        $display("two-level and uniform batches); %0d results checked, one %0d-cycle output stall.",
                 results_seen, HOLD_CYCLES);
        if (failures == 0) begin
            $display("** sigma_clipped_mean_unit: PASSED **");
        end else begin
            $display("** sigma_clipped_mean_unit: FAILED **");
        end
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("Timeout with %0d results still expected.", pending_results.size());
        $display("** sigma_clipped_mean_unit: FAILED **");
        $finish;
    end

endmodule
